### src/subor_pkg.sv
// Package for the subarray OR coverage block: sizes, the datapath
// command and status structs, and the width mask helper.
// No dependencies; used by subor_ctrl, subor_dp and the top level.
package subor_pkg;

  // Largest value width; the element, the map address and the list entries use it
  localparam int MAX_BITS   = 12;
  // Chain of growing bit sets holds at most MAX_BITS+1 entries
  localparam int LIST_DEPTH = MAX_BITS + 1;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int NUM_W      = $clog2(LIST_DEPTH + 1);
  localparam int MAP_SIZE   = 1 << MAX_BITS;

  // Width register and output count field
  localparam int WIDTH_W     = 4;
  localparam int WIDTH_RESET = 12;
  localparam int COUNT_W     = 12;

  // Presence map entries hold the array epoch that marked them
  localparam int EPOCH_W = 4;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // transfer of a new element
    logic step;        // OR one old list entry into the new list
    logic commit;      // new list replaces the old one
    logic finish;      // load result, clear per-array state
    logic clear_step;  // zero one map entry
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic list_empty;
    logic walk_last;
    logic clear_last;
    logic epoch_wrap;
    logic item_last;
  } dp_stat_t;

  // Mask of the effective width: zero acts as one, above MAX_BITS clamps
  function automatic logic [MAX_BITS-1:0] width_mask(input logic [WIDTH_W-1:0] w);
    int eff;
    logic [MAX_BITS-1:0] m;
    eff = int'(w);
    if (eff < 1) eff = 1;
    if (eff > MAX_BITS) eff = MAX_BITS;
    for (int b = 0; b < MAX_BITS; b++) begin
      m[b] = (b < eff);
    end
    return m;
  endfunction

endpackage

### src/subarray_or_coverage_top.sv
// Top level of the subarray OR coverage block: controller and datapath.
// Depends on subor_pkg, subor_ctrl and subor_dp.
// Input channel (in_valid/in_ready): one array element per transfer, with
//   last_element set on the final element. Elements are masked to the
//   width held in the register written through cfg_wr_en/cfg_wr_data
//   (reset value 12; zero acts as one, values above 12 as 12).
// Output channel (out_valid/out_ready): one transfer per array, after its
//   last element: covered_count and is_universal.
// Sequence: after an element's transfer, in_ready stays low while the
//   controller walks the OR list left by the previous element (length L,
//   0..13): one presence map mark per list value through the map's one
//   read port and one write port, then a drain state and a list commit.
//   out_valid rises with the last element's list commit.
// Reset: all 4096 presence map entries are cleared with in_ready low.
//   Arrays after that reuse the map through a 4-bit epoch mark; after
//   every 15th array the same clearing pass runs again.
// Stalls: the result sits in an output register; a stalled receiver holds
//   only the end of the next array, earlier elements keep being taken.
module subarray_or_coverage_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [subor_pkg::WIDTH_W-1:0]        cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [subor_pkg::MAX_BITS-1:0]       element,
  input  logic                                 last_element,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [subor_pkg::COUNT_W-1:0]        covered_count,
  output logic                                 is_universal
);

  subor_pkg::dp_cmd_t  cmd;
  subor_pkg::dp_stat_t stat;

  // Sequencer
  subor_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // List, map and count
  subor_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .element       (element),
    .last_element  (last_element),
    .cmd           (cmd),
    .stat          (stat),
    .covered_count (covered_count),
    .is_universal  (is_universal)
  );

endmodule

### src/subor_ctrl.sv
// Controller for the subarray OR coverage block: sequences the map clearing
// pass, the per-element list walk and the result transfer.
// Depends on subor_pkg.
module subor_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output subor_pkg::dp_cmd_t  cmd,
  input  subor_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_END
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.list_empty ? S_DRAIN : S_WALK;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (stat.walk_last) state_next = S_DRAIN;
      end
      // last map mark completes here
      S_DRAIN: begin
        state_next = S_END;
      end
      S_END: begin
        if (!stat.item_last) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end else if (slot_free) begin
          cmd.commit = 1'b1;
          cmd.finish = 1'b1;
          state_next = stat.epoch_wrap ? S_CLEAR : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A walk only starts on a nonempty list
  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> !stat.list_empty)
    else $error("list walk with empty list");

  // Result held until the receiver takes it
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // New result only into a free output slot
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> slot_free)
    else $error("result loaded over a pending one");

endmodule

### src/subor_dp.sv
// Datapath for the subarray OR coverage block: width register, OR list,
// presence map memory with epoch marks, covered count and result register.
// Depends on subor_pkg.
module subor_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [subor_pkg::WIDTH_W-1:0]        cfg_wr_data,
  input  logic [subor_pkg::MAX_BITS-1:0]       element,
  input  logic                                 last_element,
  input  subor_pkg::dp_cmd_t                   cmd,
  output subor_pkg::dp_stat_t                  stat,
  output logic [subor_pkg::COUNT_W-1:0]        covered_count,
  output logic                                 is_universal
);

  logic [subor_pkg::WIDTH_W-1:0]  value_width;
  logic [subor_pkg::MAX_BITS-1:0] load_mask;
  logic [subor_pkg::MAX_BITS-1:0] load_x;
  logic [subor_pkg::MAX_BITS-1:0] x;
  logic [subor_pkg::MAX_BITS-1:0] full;
  logic                           item_last;
  logic [subor_pkg::MAX_BITS-1:0] cur_list [subor_pkg::LIST_DEPTH];
  logic [subor_pkg::MAX_BITS-1:0] nxt_list [subor_pkg::LIST_DEPTH];
  logic [subor_pkg::NUM_W-1:0]    cur_size;
  logic [subor_pkg::NUM_W-1:0]    nxt_n;
  logic [subor_pkg::IDX_W-1:0]    idx;
  logic [subor_pkg::MAX_BITS-1:0] last_val;
  logic [subor_pkg::MAX_BITS-1:0] walk_val;
  logic                           walk_app;
  logic                           pend_valid;
  logic [subor_pkg::MAX_BITS-1:0] pend_val;
  logic                           mark_new;
  logic [subor_pkg::COUNT_W-1:0]  seen_count;
  logic [subor_pkg::EPOCH_W-1:0]  epoch;
  logic [subor_pkg::MAX_BITS-1:0] clr_addr;

  // Presence map: entry equal to the current epoch means marked
  logic [subor_pkg::EPOCH_W-1:0]  map_mem [subor_pkg::MAP_SIZE];
  logic [subor_pkg::EPOCH_W-1:0]  rd_data;
  logic [subor_pkg::MAX_BITS-1:0] map_raddr;
  logic [subor_pkg::MAX_BITS-1:0] map_waddr;
  logic [subor_pkg::EPOCH_W-1:0]  map_wdata;
  logic                           map_we;

  // Element masking and one list step
  assign load_mask = subor_pkg::width_mask(value_width);
  assign load_x    = element & load_mask;
  assign walk_val  = cur_list[idx] | x;
  assign walk_app  = (walk_val != last_val) &&
                     (nxt_n < subor_pkg::NUM_W'(subor_pkg::LIST_DEPTH));

  // Map ports: read for the value just appended, write in the following cycle
  assign map_raddr = cmd.load ? load_x : walk_val;
  assign mark_new  = pend_valid && (rd_data != epoch);
  assign map_we    = cmd.clear_step || mark_new;
  assign map_waddr = cmd.clear_step ? clr_addr : pend_val;
  assign map_wdata = cmd.clear_step ? '0 : epoch;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    rd_data <= map_mem[map_raddr];
  end

  // Status to controller
  assign stat.list_empty = (cur_size == '0);
  assign stat.walk_last  = ((subor_pkg::NUM_W'(idx) + subor_pkg::NUM_W'(1)) == cur_size);
  assign stat.clear_last = (clr_addr == '1);
  assign stat.epoch_wrap = (epoch == '1);
  assign stat.item_last  = item_last;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      value_width <= subor_pkg::WIDTH_W'(subor_pkg::WIDTH_RESET);
      cur_size    <= '0;
      nxt_n       <= '0;
      idx         <= '0;
      pend_valid  <= 1'b0;
      seen_count  <= '0;
      epoch       <= subor_pkg::EPOCH_W'(1);
      clr_addr    <= '0;
    end else begin
      if (cfg_wr_en) value_width <= cfg_wr_data;
      pend_valid <= 1'b0;
      if (cmd.load) begin
        nxt_n      <= subor_pkg::NUM_W'(1);
        idx        <= '0;
        pend_valid <= 1'b1;
      end
      if (cmd.step) begin
        idx <= idx + subor_pkg::IDX_W'(1);
        if (walk_app) begin
          nxt_n      <= nxt_n + subor_pkg::NUM_W'(1);
          pend_valid <= 1'b1;
        end
      end
      // first mark of a nonzero value counts
      if (mark_new && (pend_val != '0)) seen_count <= seen_count + subor_pkg::COUNT_W'(1);
      if (cmd.commit) cur_size <= nxt_n;
      if (cmd.finish) begin
        seen_count <= '0;
        cur_size   <= '0;
        if (epoch == '1) begin
          epoch    <= subor_pkg::EPOCH_W'(1);
          clr_addr <= '0;
        end else begin
          epoch <= epoch + subor_pkg::EPOCH_W'(1);
        end
      end
      if (cmd.clear_step) clr_addr <= clr_addr + subor_pkg::MAX_BITS'(1);
    end
  end

  // List and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x           <= load_x;
      full        <= load_mask;
      item_last   <= last_element;
      nxt_list[0] <= load_x;
      last_val    <= load_x;
      pend_val    <= load_x;
    end
    if (cmd.step) begin
      pend_val <= walk_val;
      if (walk_app) begin
        nxt_list[nxt_n[subor_pkg::IDX_W-1:0]] <= walk_val;
        last_val <= walk_val;
      end
    end
    if (cmd.commit) cur_list <= nxt_list;
    if (cmd.finish) begin
      covered_count <= seen_count;
      is_universal  <= (seen_count == subor_pkg::COUNT_W'(full));
    end
  end

  // Values of one element are distinct, so a read never hits the pending write
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(pend_valid && (cmd.load || (cmd.step && walk_app)) && (map_raddr == pend_val)))
    else $error("map read collides with pending mark");

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    cur_size <= subor_pkg::NUM_W'(subor_pkg::LIST_DEPTH))
    else $error("OR list size out of range");

  // Epoch zero is the cleared mark and never the live one
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("live epoch equals cleared mark");

endmodule
